[src/amc_pkg.sv]
// Shared constants for the ambiguity median cost unit: operation codes,
// field widths, saturation value and pipeline latency. No dependencies.
`timescale 1ns / 1ps

package amc_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int MAX_SYMBOLS_DEF = 8;
    localparam int COST_BITS_DEF   = 16;

    // Field widths fixed by the interface
    localparam int OP_BITS        = 2;
    localparam int INDEX_BITS     = 3;
    localparam int ENTRY_BITS     = 16;
    localparam int MASK_BITS      = 8;
    localparam int MIN_COST_BITS  = 18;
    localparam int ALPHABET_BITS  = 4;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_QUERY2 = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY3 = 2'd2;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    // Register index, taken from paddr bit 2
    localparam logic IDX_ALPHABET = 1'b0;

    localparam logic [ALPHABET_BITS-1:0] ALPHABET_RESET = 4'd5;

    // Saturated cost reported for empty masks and oversized sums
    localparam logic [MIN_COST_BITS-1:0] COST_SAT = 18'h3FFFF;

    // Cycles from the accepting edge to the result strobe
    localparam int LATENCY = 5;

endpackage

[src/ambiguity_median_cost_unit.sv]
// Ambiguity median cost unit: cost table, five-stage query pipeline and
// the configuration port. Depends on amc_pkg.
`timescale 1ns / 1ps

// Usage
//   Input words: raise start with the word's fields; a word is taken at each
//   edge where start is high and busy is low. busy is always low, so a word
//   can enter in every cycle (one word per cycle sustained).
//   Operation write stores entry_cost at row member_index, column
//   target_index and gives no result. Operation three is dropped.
//   Queries with two or three masks each give one result word, shown for one
//   cycle with o_done high. The pipeline stages are mask qualify, per-mask
//   minimum over table rows, per-symbol sum, minimum over symbols, tie set
//   and saturate. A write takes effect for every query accepted after it.
//   The receiver cannot stall: o_done is a one-cycle strobe and is never held.
//   alphabet_size is written over the APB port at byte address 0 and reads
//   back there; write it only while no query is in flight.
//   Reset (synchronous, active low) clears the pipeline valid bits and sets
//   alphabet_size to 5. The cost table is not cleared: read only entries
//   that have been written.
module ambiguity_median_cost_unit
    import amc_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int COST_BITS   = COST_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_BITS-1:0]        i_operation,
    input  logic [INDEX_BITS-1:0]     i_member_index,
    input  logic [INDEX_BITS-1:0]     i_target_index,
    input  logic [ENTRY_BITS-1:0]     i_entry_cost,
    input  logic [MASK_BITS-1:0]      i_first_mask,
    input  logic [MASK_BITS-1:0]      i_second_mask,
    input  logic [MASK_BITS-1:0]      i_third_mask,
    // result channel
    output logic                      o_done,
    output logic [MIN_COST_BITS-1:0]  o_min_cost,
    output logic [MASK_BITS-1:0]      o_median_set,
    output logic                      o_empty_mask,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    localparam int SUM_BITS  = COST_BITS + 2;
    localparam int WIDE_BITS = (SUM_BITS > MIN_COST_BITS) ? SUM_BITS : MIN_COST_BITS;
    localparam int NMASK     = 3;

    // configuration
    logic [ALPHABET_BITS-1:0] r_alphabet;
    logic                     cfg_wr;

    // cost table, each entry feeding its own place in the minimum trees
    logic [COST_BITS-1:0] r_table [MAX_SYMBOLS][MAX_SYMBOLS];

    // stage 1: qualified masks
    logic                   r_s1_v, r_s1_three, r_s1_empty;
    logic [MAX_SYMBOLS-1:0] r_s1_mask [NMASK];
    logic [MAX_SYMBOLS-1:0] r_s1_valid;

    // stage 2: per-mask minimum for each target
    logic                   r_s2_v, r_s2_three, r_s2_empty;
    logic [MAX_SYMBOLS-1:0] r_s2_valid;
    logic [COST_BITS-1:0]   r_s2_min [NMASK][MAX_SYMBOLS];
    logic [COST_BITS-1:0]   n_min  [NMASK][MAX_SYMBOLS];

    // stage 3: summed cost per target
    logic                   r_s3_v, r_s3_empty;
    logic [MAX_SYMBOLS-1:0] r_s3_valid;
    logic [SUM_BITS-1:0]    r_s3_sum [MAX_SYMBOLS];
    logic [SUM_BITS-1:0]    n_sum  [MAX_SYMBOLS];

    // stage 4: least sum over valid targets
    logic                   r_s4_v, r_s4_empty;
    logic [MAX_SYMBOLS-1:0] r_s4_valid;
    logic [SUM_BITS-1:0]    r_s4_sum [MAX_SYMBOLS];
    logic [SUM_BITS-1:0]    r_s4_best;
    logic [SUM_BITS-1:0]    n_best;

    // output stage
    logic                     r_done, r_empty;
    logic [MIN_COST_BITS-1:0] r_min_cost;
    logic [MASK_BITS-1:0]     r_median_set;
    logic [MAX_SYMBOLS-1:0]   n_set;
    logic [MIN_COST_BITS-1:0] n_cost;
    logic [WIDE_BITS-1:0]     best_wide;

    // input decode
    logic                   accept, is_write, is_query, is_three;
    logic [MAX_SYMBOLS-1:0] sym_valid;
    logic [MAX_SYMBOLS-1:0] in_mask [NMASK];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_write = (i_operation == OP_WRITE);
    assign is_three = (i_operation == OP_QUERY3);
    assign is_query = (i_operation == OP_QUERY2) || is_three;

    // APB: always ready, one register at index 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            IDX_ALPHABET: prdata = {{(APB_DATA_BITS-ALPHABET_BITS){1'b0}}, r_alphabet};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet <= ALPHABET_RESET;
        end else if (cfg_wr && paddr[2] == IDX_ALPHABET) begin
            r_alphabet <= pwdata[ALPHABET_BITS-1:0];
        end
    end

    // store a table entry; rows or columns past the table match nothing
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < MAX_SYMBOLS; r++) begin
            for (int c = 0; c < MAX_SYMBOLS; c++) begin
                if (accept && is_write && i_member_index == INDEX_BITS'(r)
                        && i_target_index == INDEX_BITS'(c)) begin
                    r_table[r][c] <= COST_BITS'(i_entry_cost);
                end
            end
        end
    end

    // qualify masks against the alphabet
    always_comb begin
        for (int n = 0; n < MAX_SYMBOLS; n++) begin
            sym_valid[n] = (ALPHABET_BITS'(n) < r_alphabet);
        end
        in_mask[0] = i_first_mask[MAX_SYMBOLS-1:0]  & sym_valid;
        in_mask[1] = i_second_mask[MAX_SYMBOLS-1:0] & sym_valid;
        in_mask[2] = i_third_mask[MAX_SYMBOLS-1:0]  & sym_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept && is_query;
        end
        r_s1_three <= is_three;
        r_s1_empty <= (in_mask[0] == '0) || (in_mask[1] == '0)
                      || (is_three && in_mask[2] == '0);
        r_s1_valid <= sym_valid;
        for (int i = 0; i < NMASK; i++) begin
            r_s1_mask[i] <= in_mask[i];
        end
    end

    // least cost from any member of each mask to each target
    always_comb begin
        for (int i = 0; i < NMASK; i++) begin
            for (int n = 0; n < MAX_SYMBOLS; n++) begin
                n_min[i][n] = '1;
                for (int m = 0; m < MAX_SYMBOLS; m++) begin
                    if (r_s1_mask[i][m] && r_table[m][n] < n_min[i][n]) begin
                        n_min[i][n] = r_table[m][n];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_three <= r_s1_three;
        r_s2_empty <= r_s1_empty;
        r_s2_valid <= r_s1_valid;
        r_s2_min   <= n_min;
    end

    // sum the per-mask minima; the third only for three-mask queries
    always_comb begin
        for (int n = 0; n < MAX_SYMBOLS; n++) begin
            n_sum[n] = SUM_BITS'(r_s2_min[0][n]) + SUM_BITS'(r_s2_min[1][n])
                       + (r_s2_three ? SUM_BITS'(r_s2_min[2][n]) : SUM_BITS'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
        r_s3_empty <= r_s2_empty;
        r_s3_valid <= r_s2_valid;
        r_s3_sum   <= n_sum;
    end

    // least sum over targets inside the alphabet; all-ones never is a real sum
    always_comb begin
        n_best = '1;
        for (int n = 0; n < MAX_SYMBOLS; n++) begin
            if (r_s3_valid[n] && r_s3_sum[n] < n_best) begin
                n_best = r_s3_sum[n];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
        r_s4_empty <= r_s3_empty;
        r_s4_valid <= r_s3_valid;
        r_s4_sum   <= r_s3_sum;
        r_s4_best  <= n_best;
    end

    // collect ties and saturate
    always_comb begin
        for (int n = 0; n < MAX_SYMBOLS; n++) begin
            n_set[n] = r_s4_valid[n] && (r_s4_sum[n] == r_s4_best);
        end
        best_wide = WIDE_BITS'(r_s4_best);
        if (best_wide > WIDE_BITS'(COST_SAT)) begin
            n_cost = COST_SAT;
        end else begin
            n_cost = best_wide[MIN_COST_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s4_v;
        end
        r_empty <= r_s4_empty;
        if (r_s4_empty) begin
            r_min_cost   <= COST_SAT;
            r_median_set <= '0;
        end else begin
            r_min_cost   <= n_cost;
            r_median_set <= MASK_BITS'(n_set);
        end
    end

    assign o_done       = r_done;
    assign o_min_cost   = r_min_cost;
    assign o_median_set = r_median_set;
    assign o_empty_mask = r_empty;

endmodule

[src/amc_checker.sv]
// Port-level checks for the ambiguity median cost unit, bound to the top
// level. Depends on amc_pkg and ambiguity_median_cost_unit.
`timescale 1ns / 1ps

module amc_checker
    import amc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [OP_BITS-1:0]       i_operation,
    input logic                     o_done,
    input logic [MIN_COST_BITS-1:0] o_min_cost,
    input logic [MASK_BITS-1:0]     o_median_set,
    input logic                     o_empty_mask
);

    logic query_in;

    assign query_in = start && !busy
                      && (i_operation == OP_QUERY2 || i_operation == OP_QUERY3);

    // every accepted query yields a result word after the pipeline latency
    a_query_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_in |-> ##LATENCY o_done)
        else $error("query accepted without a result word");

    // no result word without a query accepted latency cycles earlier
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(query_in, LATENCY))
        else $error("result word without a matching query");

    // empty words carry the saturated cost and no median symbol
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_empty_mask |-> o_min_cost == COST_SAT && o_median_set == '0)
        else $error("empty result word with cost or median set");

    // a non-empty word names at least one median symbol
    a_median_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_empty_mask |-> o_median_set != '0)
        else $error("non-empty result word with no median symbol");

endmodule

bind ambiguity_median_cost_unit amc_checker u_amc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_operation  (i_operation),
    .o_done       (o_done),
    .o_min_cost   (o_min_cost),
    .o_median_set (o_median_set),
    .o_empty_mask (o_empty_mask)
);
